[design/pzcs_pkg.sv]
package pzcs_pkg;

    localparam int unsigned PRICE_W = 24;
    localparam logic [23:0] PRICE_MAX = 24'hFFFFFF;
    localparam int unsigned LEVEL_W = 32;
    localparam int unsigned SCORE_W = 18;
    localparam int unsigned TERM_W = 17;
    localparam int unsigned LOOKBACK_W = 11;
    localparam int unsigned ATRWIN_W = 9;
    localparam logic [31:0] LOOKBACK_MIN = 32'd10;
    localparam logic [10:0] LOOKBACK_RST = 11'd200;
    localparam logic [8:0] ATRWIN_RST = 9'd14;

    // Register indexes on the configuration port.
    localparam logic REG_LOOKBACK = 1'b0;
    localparam logic REG_ATRWIN = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_WR   = 9'b000000010,
        ST_CL   = 9'b000000100,
        ST_SCAN = 9'b000001000,
        ST_MUL  = 9'b000010000,
        ST_PREP = 9'b000100000,
        ST_DIV  = 9'b001000000,
        ST_POST = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        JOB_PIVOT = 3'd0,
        JOB_MEAN  = 3'd1,
        JOB_TZONE = 3'd2,
        JOB_TPIV  = 3'd3,
        JOB_TMEAN = 3'd4
    } t_job;

endpackage

[design/price_zone_confluence_scorer_top.sv]
// Price zone confluence scorer.
// Input channel: one word per price bar (high, low, close in ticks) on
// i_in_valid / o_in_ready. Output channel: one word per scored bar
// (confluence score in Q2.16 plus zone midpoint, pivot and 20-bar mean close
// in ticks Q.8) on o_out_valid / i_out_ready. The first bar and any bar whose
// windowed true-range sum is zero produce no output word.
// Configuration is an APB-style port: lookback_bars at byte address 0 and
// atr_window at byte address 4. pready is always high.
// The window scan reads the high, low and true-range memories one entry per
// cycle, and a single radix-2 divider forms the pivot, the mean close and the
// three closeness terms one bit per cycle on a dividend of DIV_W = 24 +
// log2(ATR_MAX) + 25 bits (57 with default parameters). The block takes one
// bar at a time; o_in_ready is high only while it is idle.
// A finished word sits in the output register, so a new bar is accepted while
// the receiver stalls; if the next result is ready before the old one is
// taken, the block waits holding it. Reset clears counters, sums, pointers
// and the output valid; history memories need no clearing since only written
// entries are ever read.
module price_zone_confluence_scorer_top #(
    parameter int unsigned LOOKBACK_MAX = 1024,
    parameter int unsigned ATR_MAX = 256,
    parameter int unsigned MEAN_WINDOW = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [pzcs_pkg::PRICE_W-1:0]          i_high_price,
    input  logic [pzcs_pkg::PRICE_W-1:0]          i_low_price,
    input  logic [pzcs_pkg::PRICE_W-1:0]          i_close_price,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [pzcs_pkg::SCORE_W-1:0]          o_confluence_score,
    output logic [pzcs_pkg::LEVEL_W-1:0]          o_zone_mid,
    output logic [pzcs_pkg::LEVEL_W-1:0]          o_pivot_level,
    output logic [pzcs_pkg::LEVEL_W-1:0]          o_mean_close,
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [2:0]                            i_paddr,
    input  logic [31:0]                           i_pwdata,
    output logic [31:0]                           o_prdata,
    output logic                                  o_pready
);

    localparam int unsigned HL_AW = (LOOKBACK_MAX > 1) ? $clog2(LOOKBACK_MAX) : 1;
    localparam int unsigned TR_AW = (ATR_MAX > 1) ? $clog2(ATR_MAX) : 1;
    localparam int unsigned CL_AW = (MEAN_WINDOW > 1) ? $clog2(MEAN_WINDOW) : 1;
    localparam int unsigned SPAN = (LOOKBACK_MAX > ATR_MAX) ? LOOKBACK_MAX : ATR_MAX;
    localparam int unsigned CNT_W = $clog2(SPAN + 1);
    localparam int unsigned KW = $clog2(ATR_MAX + 1);
    localparam int unsigned MC_W = $clog2(MEAN_WINDOW + 1);
    localparam int unsigned RS_W = 24 + $clog2(ATR_MAX);
    localparam int unsigned CS_W = 24 + $clog2(MEAN_WINDOW);
    localparam int unsigned DIV_W = RS_W + 25;
    localparam int unsigned DEN_A = RS_W + 8;
    localparam int unsigned DEN_B = KW + 32;
    localparam int unsigned DEN_W = ((DEN_A > DEN_B) ? DEN_A : DEN_B) + 1;
    localparam int unsigned DC_W = $clog2(DIV_W + 1);

    // Configuration registers.
    logic [pzcs_pkg::LOOKBACK_W-1:0] r_lookback;
    logic [pzcs_pkg::ATRWIN_W-1:0]   r_atrwin;
    logic                            cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr = i_psel & i_penable & i_pwrite;
    assign o_prdata = (i_paddr[2] == pzcs_pkg::REG_ATRWIN) ? {23'd0, r_atrwin}
                                                           : {21'd0, r_lookback};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookback <= pzcs_pkg::LOOKBACK_RST;
            r_atrwin <= pzcs_pkg::ATRWIN_RST;
        end else if (cfg_wr) begin
            if (i_paddr[2] == pzcs_pkg::REG_LOOKBACK) begin
                r_lookback <= i_pwdata[pzcs_pkg::LOOKBACK_W-1:0];
            end else begin
                r_atrwin <= i_pwdata[pzcs_pkg::ATRWIN_W-1:0];
            end
        end
    end

    // History memories.
    logic [23:0] mem_high [LOOKBACK_MAX];
    logic [23:0] mem_low [LOOKBACK_MAX];
    logic [23:0] mem_tr [ATR_MAX];
    logic [23:0] mem_close [MEAN_WINDOW];
    logic [23:0] r_high_rd, r_low_rd, r_tr_rd, r_close_rd;

    pzcs_pkg::t_state r_state;
    pzcs_pkg::t_job   r_job;

    logic [23:0] r_h, r_l, r_c, r_prev_close;
    logic [31:0] r_bars;
    logic [HL_AW-1:0] r_hl_pos, r_hl_rp;
    logic [TR_AW-1:0] r_tr_pos, r_tr_rp;
    logic [CL_AW-1:0] r_cl_pos;
    logic [CS_W-1:0]  r_close_sum;
    logic [CNT_W-1:0] r_cnt, r_len, r_i;
    logic [KW-1:0]    r_ak;
    logic [MC_W-1:0]  r_mc;
    logic             r_pv, r_pv_hl, r_pv_tr;
    logic [23:0]      r_hi, r_lo;
    logic [RS_W-1:0]  r_rsum;
    logic [31:0]      r_zone8, r_pivot8, r_mean8;
    logic [DEN_B-1:0] r_prod;
    logic [DIV_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_dvs, r_rem;
    logic [DC_W-1:0]  r_dcnt;
    logic [pzcs_pkg::SCORE_W-1:0] r_score;
    logic             r_out_valid;
    logic [pzcs_pkg::SCORE_W-1:0] r_out_score;
    logic [31:0]      r_out_zone, r_out_pivot, r_out_mean;

    logic        in_acc;
    logic [23:0] tr_val, d_hl, d_hp, d_lp;
    logic [31:0] lb32, nw32, cnt32, ak32, mc32;
    logic [31:0] c8, ref8, d8;
    logic [DEN_W-1:0] den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;

    assign o_in_ready = (r_state == pzcs_pkg::ST_IDLE);
    assign in_acc = i_in_valid & o_in_ready;

    always_comb begin
        d_hl = (r_h > r_l) ? (r_h - r_l) : 24'd0;
        d_hp = (r_h > r_prev_close) ? (r_h - r_prev_close) : (r_prev_close - r_h);
        d_lp = (r_l > r_prev_close) ? (r_l - r_prev_close) : (r_prev_close - r_l);
        tr_val = d_hl;
        if (d_hp > tr_val) tr_val = d_hp;
        if (d_lp > tr_val) tr_val = d_lp;

        lb32 = {21'd0, r_lookback};
        if (lb32 < pzcs_pkg::LOOKBACK_MIN) lb32 = pzcs_pkg::LOOKBACK_MIN;
        if (lb32 > 32'(LOOKBACK_MAX)) lb32 = 32'(LOOKBACK_MAX);
        cnt32 = (r_bars < lb32) ? r_bars : lb32;
        nw32 = {23'd0, r_atrwin};
        if (nw32 < 32'd1) nw32 = 32'd1;
        if (nw32 > 32'(ATR_MAX)) nw32 = 32'(ATR_MAX);
        ak32 = ((r_bars - 32'd1) < nw32) ? (r_bars - 32'd1) : nw32;
        mc32 = (r_bars < 32'(MEAN_WINDOW)) ? r_bars : 32'(MEAN_WINDOW);

        c8 = {r_c, 8'd0};
        case (r_job)
            pzcs_pkg::JOB_TZONE: ref8 = r_zone8;
            pzcs_pkg::JOB_TPIV:  ref8 = r_pivot8;
            default:             ref8 = r_mean8;
        endcase
        d8 = (c8 > ref8) ? (c8 - ref8) : (ref8 - c8);
        den = DEN_W'({r_rsum, 8'd0}) + DEN_W'(r_prod);

        rem_sh = {r_rem, r_dvd[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // Memory ports: written only in the states that own them, read every cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == pzcs_pkg::ST_WR) begin
            mem_high[r_hl_pos] <= r_h;
            mem_low[r_hl_pos] <= r_l;
        end
        r_high_rd <= mem_high[r_hl_rp];
        r_low_rd <= mem_low[r_hl_rp];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pzcs_pkg::ST_WR && r_bars >= 32'd2) begin
            mem_tr[r_tr_pos] <= tr_val;
        end
        r_tr_rd <= mem_tr[r_tr_rp];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pzcs_pkg::ST_CL) begin
            mem_close[r_cl_pos] <= r_c;
        end
        r_close_rd <= mem_close[r_cl_pos];
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_h <= i_high_price;
            r_l <= i_low_price;
            r_c <= i_close_price;
        end
        unique case (r_state)
            pzcs_pkg::ST_WR: begin
                r_cnt <= CNT_W'(cnt32);
                r_ak <= KW'(ak32);
                r_mc <= MC_W'(mc32);
                r_len <= (CNT_W'(cnt32) > CNT_W'(ak32)) ? CNT_W'(cnt32) : CNT_W'(ak32);
            end
            pzcs_pkg::ST_CL: begin
                r_i <= '0;
                r_hi <= '0;
                r_lo <= pzcs_pkg::PRICE_MAX;
                r_rsum <= '0;
            end
            pzcs_pkg::ST_SCAN: begin
                if (r_i != r_len) begin
                    r_i <= r_i + 1'b1;
                end
                r_pv_hl <= (r_i < r_cnt);
                r_pv_tr <= (CNT_W'(r_i) < CNT_W'(r_ak));
                if (r_pv && r_pv_hl) begin
                    if (r_high_rd > r_hi) r_hi <= r_high_rd;
                    if (r_low_rd < r_lo) r_lo <= r_low_rd;
                end
                if (r_pv && r_pv_tr) begin
                    r_rsum <= r_rsum + RS_W'(r_tr_rd);
                end
                r_zone8 <= {7'd0, ({1'b0, r_hi} + {1'b0, r_lo})} << 7;
                r_score <= '0;
            end
            pzcs_pkg::ST_MUL: begin
                r_prod <= DEN_B'(r_ak) * DEN_B'(d8);
            end
            pzcs_pkg::ST_PREP: begin
                r_rem <= '0;
                r_dcnt <= '0;
                case (r_job)
                    pzcs_pkg::JOB_PIVOT: begin
                        r_dvd <= DIV_W'({({2'd0, r_h} + {2'd0, r_l} + {2'd0, r_c}), 8'd0})
                                 + DIV_W'(1);
                        r_dvs <= DEN_W'(3);
                    end
                    pzcs_pkg::JOB_MEAN: begin
                        r_dvd <= DIV_W'({r_close_sum, 8'd0}) + DIV_W'(r_mc >> 1);
                        r_dvs <= DEN_W'(r_mc);
                    end
                    default: begin
                        r_dvd <= DIV_W'({r_rsum, 24'd0}) + DIV_W'(den >> 1);
                        r_dvs <= den;
                    end
                endcase
            end
            pzcs_pkg::ST_DIV: begin
                r_dcnt <= r_dcnt + 1'b1;
                if (!rem_sub[DEN_W]) begin
                    r_rem <= rem_sub[DEN_W-1:0];
                    r_dvd <= {r_dvd[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DEN_W-1:0];
                    r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
                end
            end
            pzcs_pkg::ST_POST: begin
                case (r_job)
                    pzcs_pkg::JOB_PIVOT: r_pivot8 <= r_dvd[31:0];
                    pzcs_pkg::JOB_MEAN:  r_mean8 <= r_dvd[31:0];
                    default: r_score <= r_score
                                        + pzcs_pkg::SCORE_W'(r_dvd[pzcs_pkg::TERM_W-1:0]);
                endcase
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pzcs_pkg::ST_IDLE;
            r_job <= pzcs_pkg::JOB_PIVOT;
            r_bars <= '0;
            r_prev_close <= '0;
            r_hl_pos <= '0;
            r_hl_rp <= '0;
            r_tr_pos <= '0;
            r_tr_rp <= '0;
            r_cl_pos <= '0;
            r_close_sum <= '0;
            r_pv <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the output state the word register is handled below.
            if (r_out_valid && i_out_ready && r_state != pzcs_pkg::ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                pzcs_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (r_bars != 32'hFFFFFFFF) r_bars <= r_bars + 32'd1;
                        r_state <= pzcs_pkg::ST_WR;
                    end
                end
                pzcs_pkg::ST_WR: begin
                    r_hl_rp <= r_hl_pos;
                    r_hl_pos <= (32'(r_hl_pos) == LOOKBACK_MAX - 1) ? '0 : r_hl_pos + 1'b1;
                    if (r_bars >= 32'd2) begin
                        r_tr_rp <= r_tr_pos;
                        r_tr_pos <= (32'(r_tr_pos) == ATR_MAX - 1) ? '0 : r_tr_pos + 1'b1;
                    end
                    r_prev_close <= r_c;
                    r_state <= pzcs_pkg::ST_CL;
                end
                pzcs_pkg::ST_CL: begin
                    r_close_sum <= r_close_sum + CS_W'(r_c)
                                   - ((r_bars > 32'(MEAN_WINDOW)) ? CS_W'(r_close_rd) : '0);
                    r_cl_pos <= (32'(r_cl_pos) == MEAN_WINDOW - 1) ? '0 : r_cl_pos + 1'b1;
                    r_pv <= 1'b0;
                    r_state <= (r_bars < 32'd2) ? pzcs_pkg::ST_IDLE : pzcs_pkg::ST_SCAN;
                end
                pzcs_pkg::ST_SCAN: begin
                    if (r_i != r_len) begin
                        r_pv <= 1'b1;
                        r_hl_rp <= (r_hl_rp == '0) ? HL_AW'(LOOKBACK_MAX - 1) : r_hl_rp - 1'b1;
                        r_tr_rp <= (r_tr_rp == '0) ? TR_AW'(ATR_MAX - 1) : r_tr_rp - 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_job <= pzcs_pkg::JOB_PIVOT;
                            r_state <= (r_rsum == '0) ? pzcs_pkg::ST_IDLE : pzcs_pkg::ST_MUL;
                        end
                    end
                end
                pzcs_pkg::ST_MUL: begin
                    r_state <= pzcs_pkg::ST_PREP;
                end
                pzcs_pkg::ST_PREP: begin
                    r_state <= pzcs_pkg::ST_DIV;
                end
                pzcs_pkg::ST_DIV: begin
                    if (32'(r_dcnt) == DIV_W - 1) r_state <= pzcs_pkg::ST_POST;
                end
                pzcs_pkg::ST_POST: begin
                    case (r_job)
                        pzcs_pkg::JOB_PIVOT: r_job <= pzcs_pkg::JOB_MEAN;
                        pzcs_pkg::JOB_MEAN:  r_job <= pzcs_pkg::JOB_TZONE;
                        pzcs_pkg::JOB_TZONE: r_job <= pzcs_pkg::JOB_TPIV;
                        default:             r_job <= pzcs_pkg::JOB_TMEAN;
                    endcase
                    r_state <= (r_job == pzcs_pkg::JOB_TMEAN) ? pzcs_pkg::ST_OUT
                                                              : pzcs_pkg::ST_MUL;
                end
                pzcs_pkg::ST_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state <= pzcs_pkg::ST_IDLE;
                    end
                end
                default: r_state <= pzcs_pkg::ST_IDLE;
            endcase
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (r_state == pzcs_pkg::ST_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_score <= r_score;
            r_out_zone <= r_zone8;
            r_out_pivot <= r_pivot8;
            r_out_mean <= r_mean8;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_confluence_score = r_out_score;
    assign o_zone_mid = r_out_zone;
    assign o_pivot_level = r_out_pivot;
    assign o_mean_close = r_out_mean;

    // A bar is never accepted twice in a row: each one runs through the memories first.
    a_one_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("bar accepted while previous bar in progress");

    // The close ring pointer stays inside the window.
    a_cl_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cl_pos) < MEAN_WINDOW)
        else $error("close pointer out of range");

    // Three Q.16 terms of at most one each bound the score.
    a_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_confluence_score <= 18'd196608))
        else $error("confluence score out of range");

endmodule

[test/pzcs_checker.sv]
`timescale 1ns / 1ps

module pzcs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_high_price,
    input  logic [23:0] i_low_price,
    input  logic [23:0] i_close_price,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [17:0] i_confluence_score,
    input  logic [31:0] i_zone_mid,
    input  logic [31:0] i_pivot_level,
    input  logic [31:0] i_mean_close,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int HL_DEPTH = 1024;
    localparam int TR_DEPTH = 256;
    localparam int CL_DEPTH = 20;

    typedef struct packed {
        logic [17:0] score;
        logic [31:0] zone;
        logic [31:0] pivot;
        logic [31:0] mean;
    } t_scored_bar;

    t_scored_bar scored_q[$];

    logic [23:0] high_mem [HL_DEPTH];
    logic [23:0] low_mem [HL_DEPTH];
    logic [23:0] close_mem [CL_DEPTH];
    logic [24:0] tr_mem [TR_DEPTH];
    logic [31:0] close_total;
    logic [31:0] bar_count;
    logic [23:0] last_close;
    int hl_wr, cl_wr, tr_wr;
    logic [10:0] lookback_reg;
    logic [8:0] atrwin_reg;

    function automatic logic [63:0] closeness(logic [63:0] s, logic [63:0] k,
                                              logic [63:0] c8, logic [63:0] r8);
        logic [63:0] d8, den;
        d8 = (c8 > r8) ? c8 - r8 : r8 - c8;
        den = (s << 8) + k * d8;
        return ((s << 24) + den / 2) / den;
    endfunction

    task automatic take_bar(logic [23:0] h, logic [23:0] l, logic [23:0] c);
        longint a, b, d, tr;
        logic [63:0] n, ak, cnt, lb, nw, tr_total, mc, zone8, piv8, mean8, c8, sc;
        logic [23:0] hi, lo;
        int idx;
        t_scored_bar e;
        if (bar_count != 32'hFFFFFFFF) bar_count = bar_count + 32'd1;
        n = 64'(bar_count);
        if (n >= 2) begin
            a = longint'(h) - longint'(l);
            b = longint'(h) - longint'(last_close);
            d = longint'(l) - longint'(last_close);
            if (b < 0) b = -b;
            if (d < 0) d = -d;
            tr = a;
            if (b > tr) tr = b;
            if (d > tr) tr = d;
            tr_mem[tr_wr] = tr[24:0];
            tr_wr = (tr_wr + 1) % TR_DEPTH;
        end
        high_mem[hl_wr] = h;
        low_mem[hl_wr] = l;
        hl_wr = (hl_wr + 1) % HL_DEPTH;
        if (n > CL_DEPTH) close_total = close_total - 32'(close_mem[cl_wr]);
        close_mem[cl_wr] = c;
        close_total = close_total + 32'(c);
        cl_wr = (cl_wr + 1) % CL_DEPTH;
        last_close = c;
        if (n < 2) return;

        nw = 64'(atrwin_reg);
        if (nw < 1) nw = 1;
        if (nw > TR_DEPTH) nw = TR_DEPTH;
        ak = (nw < n - 1) ? nw : n - 1;
        tr_total = 0;
        for (int i = 0; i < ak; i++) begin
            idx = (tr_wr - 1 - i + 2 * TR_DEPTH) % TR_DEPTH;
            tr_total += 64'(tr_mem[idx]);
        end
        if (tr_total == 0) return;

        lb = 64'(lookback_reg);
        if (lb < 10) lb = 10;
        if (lb > HL_DEPTH) lb = HL_DEPTH;
        cnt = (n < lb) ? n : lb;
        hi = 0;
        lo = pzcs_pkg::PRICE_MAX;
        for (int i = 0; i < cnt; i++) begin
            idx = (hl_wr - 1 - i + 2 * HL_DEPTH) % HL_DEPTH;
            if (high_mem[idx] > hi) hi = high_mem[idx];
            if (low_mem[idx] < lo) lo = low_mem[idx];
        end
        zone8 = (64'(hi) + 64'(lo)) * 128;
        piv8 = ((64'(h) + 64'(l) + 64'(c)) * 256 + 1) / 3;
        mc = (n < CL_DEPTH) ? n : CL_DEPTH;
        mean8 = (64'(close_total) * 256 + mc / 2) / mc;
        c8 = 64'(c) * 256;
        sc = closeness(tr_total, ak, c8, zone8) + closeness(tr_total, ak, c8, piv8)
           + closeness(tr_total, ak, c8, mean8);
        e.score = sc[17:0];
        e.zone = zone8[31:0];
        e.pivot = piv8[31:0];
        e.mean = mean8[31:0];
        scored_q.push_back(e);
    endtask

    assign o_pending = scored_q.size();

    always @(posedge i_clk) begin
        t_scored_bar e;
        if (!i_rst_n) begin
            scored_q.delete();
            close_total = 0;
            bar_count = 0;
            last_close = 0;
            hl_wr = 0;
            cl_wr = 0;
            tr_wr = 0;
            lookback_reg = pzcs_pkg::LOOKBACK_RST;
            atrwin_reg = pzcs_pkg::ATRWIN_RST;
            o_fail_count = 0;
        end else begin
            // Compare before predicting: a word leaving now was caused by an earlier bar.
            if (i_out_valid && i_out_ready) begin
                if (scored_q.size() == 0) begin
                    $display("%0t: unexpected word score=%0d zone=%0d", $time,
                             i_confluence_score, i_zone_mid);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    e = scored_q.pop_front();
                    if (e.score !== i_confluence_score || e.zone !== i_zone_mid ||
                        e.pivot !== i_pivot_level || e.mean !== i_mean_close) begin
                        $display("%0t: mismatch exp score=%0d zone=%0d pivot=%0d mean=%0d",
                                 $time, e.score, e.zone, e.pivot, e.mean);
                        $display("%0t:          act score=%0d zone=%0d pivot=%0d mean=%0d",
                                 $time, i_confluence_score, i_zone_mid, i_pivot_level,
                                 i_mean_close);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite) begin
                if (i_paddr[2] == pzcs_pkg::REG_LOOKBACK) lookback_reg = i_pwdata[10:0];
                else atrwin_reg = i_pwdata[8:0];
            end
            if (i_in_valid && i_in_ready) take_bar(i_high_price, i_low_price, i_close_price);
        end
    end
endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [23:0] high_price = '0;
    logic [23:0] low_price = '0;
    logic [23:0] close_price = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [17:0] score;
    logic [31:0] zone_mid, pivot_level, mean_close;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    logic [23:0] walk_close;

    always #5 clk = ~clk;

    price_zone_confluence_scorer_top uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_high_price(high_price), .i_low_price(low_price), .i_close_price(close_price),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_confluence_score(score), .o_zone_mid(zone_mid),
        .o_pivot_level(pivot_level), .o_mean_close(mean_close),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    pzcs_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_high_price(high_price), .i_low_price(low_price), .i_close_price(close_price),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_confluence_score(score), .i_zone_mid(zone_mid),
        .i_pivot_level(pivot_level), .i_mean_close(mean_close),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls on its own pattern: phases of always-ready alternate
    // with phases where ready follows a random draw of varying density.
    always @(posedge clk) begin
        int phase;
        phase = int'(($time / 40000) % 3);
        if (!rst_n) out_ready <= 1'b0;
        else if (phase == 0) out_ready <= 1'b1;
        else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 7) == 0);
    end

    // One register write: a setup phase, then an access phase. The register
    // index is turned into its byte address.
    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one bar and hold it until the block takes it. Valid stays high
    // afterwards; the block stays busy with that bar, and the next bar
    // or an idle gap takes over before it is ready again.
    task automatic send_bar(logic [23:0] h, logic [23:0] l, logic [23:0] c);
        in_valid <= 1'b1;
        high_price <= h;
        low_price <= l;
        close_price <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Wait until every scored bar is out, then let any bar that scores
    // nothing finish its scan before a register changes.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
    endtask

    // A realistic bar around a drifting close; now and then a random
    // corner: high below low, full-scale jumps, or a flat bar.
    task automatic random_bar;
        logic [23:0] h, l, c;
        int span, kind;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            h = 24'($urandom);
            l = 24'($urandom);
            c = 24'($urandom);
        end else if (kind == 1) begin
            h = walk_close;
            l = walk_close;
            c = walk_close;
        end else begin
            span = $urandom_range(0, (kind < 5) ? 60000 : 400);
            if ($urandom_range(0, 1) != 0 && walk_close < 24'hFF0000) begin
                walk_close += 24'(span / 3);
            end else if (walk_close > 24'h00F000) begin
                walk_close -= 24'(span / 3);
            end
            h = 24'(walk_close + $urandom_range(0, span));
            l = 24'(walk_close - $urandom_range(0, span));
            c = 24'(l + $urandom_range(0, span));
        end
        send_bar(h, l, c);
    endtask

    // Sender bursts of random length followed by random gaps; some bursts
    // run back to back with no gap at all.
    task automatic random_bars(int count);
        int sent, burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                random_bar();
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 700)) @(posedge clk);
            end
        end
    endtask

    initial begin
        walk_close = 24'h400000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: the first bar gives nothing, a flat
        // second bar has zero true range and gives nothing, then the extremes.
        send_bar(24'd1000, 24'd1000, 24'd1000);
        send_bar(24'd1000, 24'd1000, 24'd1000);
        send_bar(pzcs_pkg::PRICE_MAX, 24'd0, pzcs_pkg::PRICE_MAX);
        send_bar(24'd0, pzcs_pkg::PRICE_MAX, 24'd0);
        send_bar(pzcs_pkg::PRICE_MAX, pzcs_pkg::PRICE_MAX, pzcs_pkg::PRICE_MAX);
        send_bar(24'd0, 24'd0, 24'd0);
        send_bar(24'h555555, 24'hAAAAAA, 24'h123456);
        send_bar(24'hAAAAAA, 24'h555555, 24'hEDCBA9);
        send_bar(24'd7, 24'd3, 24'd5);
        drain();

        // Minimum windows, written with out-of-range values that clamp.
        write_reg(pzcs_pkg::REG_LOOKBACK, 32'd0);
        write_reg(pzcs_pkg::REG_ATRWIN, 32'd0);
        for (int i = 0; i < 12; i++) begin
            send_bar(24'(50 + i), 24'd40, 24'(45 + (i % 3)));
        end
        drain();
        random_bars(300);
        drain();

        // Largest in-range windows, then values above range that clamp.
        write_reg(pzcs_pkg::REG_LOOKBACK, 32'd1024);
        write_reg(pzcs_pkg::REG_ATRWIN, 32'd256);
        random_bars(200);
        drain();
        write_reg(pzcs_pkg::REG_LOOKBACK, 32'h7FF);
        write_reg(pzcs_pkg::REG_ATRWIN, 32'h1FF);
        random_bars(150);
        drain();

        // Small windows with random content keep the run short.
        for (int p = 0; p < 6; p++) begin
            write_reg(pzcs_pkg::REG_LOOKBACK, $urandom_range(10, 64));
            write_reg(pzcs_pkg::REG_ATRWIN, $urandom_range(1, 32));
            random_bars(125);
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // The time limit allows for the worst-case work per bar plus output stalls and gaps.
    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
design/pzcs_pkg.sv
design/price_zone_confluence_scorer_top.sv
test/pzcs_checker.sv
test/tb.sv
